@@ src/dos_pkg.sv @@
// Shared types, constants and helpers for the depth order sorter.
`timescale 1ns / 1ps
package dos_pkg;

  localparam int NumChairsDef = 8;
  localparam int KeyW = 16;
  localparam int IdxW = 5;
  localparam int DrawW = 4;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic signed [KeyW-1:0] bottom_key;
    logic                   last_key;
  } in_item_t;

  typedef struct packed {
    logic [DrawW-1:0] draw_index;
    logic             last_draw;
  } out_item_t;

  typedef struct packed {
    logic                   valid;
    logic                   tail;
    logic signed [KeyW-1:0] key;
    logic [IdxW-1:0]        idx;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } chain_ctrl_t;

  function automatic logic [KeyW:0] sort_key(input entry_t e);
    sort_key = {e.tail, ~e.key[KeyW-1], e.key[KeyW-2:0]};
  endfunction

endpackage

@@ src/dos_cell.sv @@
// One cell of the insertion chain: holds one entry and trades with its neighbors.
`timescale 1ns / 1ps
module dos_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dos_pkg::chain_ctrl_t ctrl,
  input  dos_pkg::entry_t      new_entry,
  input  dos_pkg::entry_t      prev_entry,
  input  logic                 prev_gt,
  input  dos_pkg::entry_t      next_entry,
  output dos_pkg::entry_t      entry,
  output logic                 gt
);
  import dos_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  assign entry = entry_r;
  assign gt = !entry_r.valid || (sort_key(entry_r) > sort_key(new_entry));

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.shift) begin
      entry_nxt = next_entry;
    end else if (ctrl.insert && gt) begin
      entry_nxt = prev_gt ? prev_entry : new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

endmodule

@@ src/dos_ctrl.sv @@
// Frame sequencer: counts loaded keys and drives the drain of the chain.
`timescale 1ns / 1ps
module dos_ctrl #(
  parameter int SlotCount = dos_pkg::NumChairsDef + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   last_key,
  input  logic                   out_stall,
  output logic                   in_stall,
  output logic                   out_valid,
  output logic                   last_draw,
  output logic [dos_pkg::IdxW-1:0] load_idx,
  output dos_pkg::chain_ctrl_t   ctrl
);
  import dos_pkg::*;

  localparam int CntW = $clog2(SlotCount + 1);

  state_t          state_r, state_nxt;
  logic [CntW-1:0] load_count_r, load_count_nxt;
  logic [CntW-1:0] rem_r, rem_nxt;
  logic [CntW-1:0] cnt_after;
  logic            accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      load_count_r <= '0;
      rem_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      load_count_r <= load_count_nxt;
      rem_r        <= rem_nxt;
    end
  end

  assign load_idx = IdxW'(load_count_r);

  always_comb begin
    state_nxt      = state_r;
    load_count_nxt = load_count_r;
    rem_nxt        = rem_r;
    in_stall       = 1'b1;
    out_valid      = 1'b0;
    last_draw      = 1'b0;
    accept         = 1'b0;
    cnt_after      = load_count_r;
    ctrl           = '0;
    case (state_r)
      ST_LOAD: begin
        in_stall    = 1'b0;
        accept      = in_valid;
        ctrl.insert = accept && (load_count_r < CntW'(SlotCount));
        cnt_after   = ctrl.insert ? load_count_r + CntW'(1) : load_count_r;
        if (accept) begin
          load_count_nxt = cnt_after;
          if (last_key) begin
            rem_nxt        = cnt_after;
            load_count_nxt = '0;
            state_nxt      = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        out_valid  = 1'b1;
        last_draw  = (rem_r == CntW'(1));
        ctrl.shift = !out_stall;
        if (!out_stall) begin
          rem_nxt = rem_r - CntW'(1);
          if (rem_r == CntW'(1)) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

@@ src/depth_order_sorter.sv @@
// Top level of the depth order sorter: sequencer, chain of insertion cells, mode register.
// A frame loads one key per cycle, the player first and then the chairs; each key is
// dropped into place in a chain of NUM_CHAIRS+1 cells in the cycle it arrives. The transfer
// that carries last_key starts the draw order, which leaves from the head of the chain at
// one index per cycle unless out_stall holds it, while the input is stalled. Equal keys
// keep their load order; with desk_mode set the player sorts behind every chair.
`timescale 1ns / 1ps
module depth_order_sorter #(
  parameter int NUM_CHAIRS = dos_pkg::NumChairsDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dos_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output dos_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);
  import dos_pkg::*;

  localparam int SlotCount = NUM_CHAIRS + 1;

  logic            desk_mode_r;
  logic [IdxW-1:0] load_idx;
  logic            last_draw;
  chain_ctrl_t     ctrl;
  entry_t          new_entry;
  entry_t          cells [SlotCount];
  logic            gts [SlotCount];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desk_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      desk_mode_r <= cfg_data;
    end
  end

  dos_ctrl #(
    .SlotCount(SlotCount)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .last_key (in_data.last_key),
    .out_stall(out_stall),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .last_draw(last_draw),
    .load_idx (load_idx),
    .ctrl     (ctrl)
  );

  always_comb begin
    new_entry.valid = 1'b1;
    new_entry.tail  = desk_mode_r && (load_idx == '0);
    new_entry.key   = in_data.bottom_key;
    new_entry.idx   = load_idx;
  end

  for (genvar i = 0; i < SlotCount; i++) begin : g_cell
    entry_t prev_e;
    logic   prev_g;
    entry_t next_e;
    if (i == 0) begin : g_head
      assign prev_e = '0;
      assign prev_g = 1'b0;
    end else begin : g_mid
      assign prev_e = cells[i-1];
      assign prev_g = gts[i-1];
    end
    if (i == SlotCount - 1) begin : g_end
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = cells[i+1];
    end
    dos_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .new_entry (new_entry),
      .prev_entry(prev_e),
      .prev_gt   (prev_g),
      .next_entry(next_e),
      .entry     (cells[i]),
      .gt        (gts[i])
    );
  end

  assign out_data.draw_index = DrawW'(cells[0].idx);
  assign out_data.last_draw  = last_draw;

endmodule

@@ src/dos_checker.sv @@
// Port-level checks on the depth order sorter, bound to the top level.
`timescale 1ns / 1ps
module dos_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input dos_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input dos_pkg::out_item_t out_data
);
  import dos_pkg::*;

  a_no_load_while_draw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a draw order is pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed or vanished");

  a_last_starts_draw: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.last_key) |=> out_valid)
    else $error("final key transfer did not start the draw order");

  a_frame_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.last_draw) |=> !out_valid)
    else $error("results continued after the final draw");

endmodule

bind depth_order_sorter dos_checker u_dos_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
